// ===== hdl/dq_pkg.sv =====
`timescale 1ns / 1ps

package dq_pkg;

    // Storage geometry of the ring.
    localparam int DEPTH   = 1024;
    localparam int DATA_W  = 32;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    // Fixed widths of the beat fields.
    localparam int CMD_W   = 3;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 11;

    // Command codes; codes above CMD_QUERY act as a query.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_QUERY      = 3'd4
    } t_cmd;

    // Result status codes.
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_REPORT
    } t_state;

    // One input beat.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [WORD_W-1:0] push_value;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [WORD_W-1:0]  popped_value;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] entry_count;
        logic               is_empty;
        logic [WORD_W-1:0]  front_word;
        logic [WORD_W-1:0]  back_word;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_fetch;
    } t_dp_stat;

endpackage

// ===== hdl/double_ended_queue.sv =====
`timescale 1ns / 1ps

// Bounded double-ended queue of 1024 words of 32 bits held in a ring memory
// with one write port and one registered read port, plus cached front and back
// words. A command beat is taken at a
// clock edge with start high and busy low, and exactly one result beat follows,
// shown on o_result for the single cycle in which o_done is high. The receiver
// cannot stall: it must capture every result in that cycle. Pushes, refused
// pushes, failed pops and queries pass through the execute state and then show
// their result; a successful pop also passes through a fetch state, since the
// ring memory's registered read port must refill the exposed end word. busy is
// low in the result cycle, so a new command may be taken there; while busy is
// high, no new command is taken. A pop on an empty queue reports status empty
// and a push on a full queue reports status full; neither changes the
// contents. The front and back words read zero when the queue is empty.

module double_ended_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  dq_pkg::t_item   i_item,
    output logic            busy,
    output logic            o_done,
    output dq_pkg::t_result o_result
);
    import dq_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer for one command beat.
    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Ring memory, pointers and result fields.
    dq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule

// ===== hdl/dq_dp.sv =====
`timescale 1ns / 1ps

module dq_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dq_pkg::t_dp_cmd  i_cmd,
    input  dq_pkg::t_item    i_item,
    output dq_pkg::t_dp_stat o_stat,
    output dq_pkg::t_result  o_result
);
    import dq_pkg::*;

    // Ring storage and its registered read port.
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    // Pointers, occupancy and the cached end words.
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [DATA_W-1:0] r_front, n_front;
    logic [DATA_W-1:0] r_back, n_back;

    // Latched command beat and per-item result fields.
    t_item             r_item, n_item;
    logic [STAT_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_popped, n_popped;

    // Memory port controls.
    logic              w_we;
    logic [PTR_W-1:0]  w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [PTR_W-1:0]  w_raddr;

    logic              w_full;
    logic              w_empty;
    logic              w_is_pop;
    logic              w_is_push;
    logic [DATA_W-1:0] w_value;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        if (p == '0) begin
            return PTR_W'(DEPTH - 1);
        end
        return p - PTR_W'(1);
    endfunction

    assign w_full    = (r_count == CNT_W'(DEPTH));
    assign w_empty   = (r_count == '0);
    assign w_is_pop  = (r_item.cmd == CMD_POP_FRONT) || (r_item.cmd == CMD_POP_BACK);
    assign w_is_push = (r_item.cmd == CMD_PUSH_FRONT) || (r_item.cmd == CMD_PUSH_BACK);
    assign w_value   = DATA_W'(r_item.push_value);

    // A successful pop must refill the cached end word from the ring.
    assign o_stat.need_fetch = w_is_pop && !w_empty;

    // Next-state logic for pointers, end words and result fields.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_count  = r_count;
        n_front  = r_front;
        n_back   = r_back;
        n_item   = r_item;
        n_status = r_status;
        n_popped = r_popped;
        w_we     = 1'b0;
        w_waddr  = r_tail;
        w_wdata  = w_value;
        w_raddr  = ptr_next(r_head);

        if (i_cmd.load) begin
            n_item = i_item;
        end

        if (i_cmd.exec) begin
            n_status = ST_OK;
            n_popped = '0;
            case (r_item.cmd)
                CMD_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_head  = ptr_prev(r_head);
                        w_we    = 1'b1;
                        w_waddr = ptr_prev(r_head);
                        n_count = r_count + CNT_W'(1);
                        n_front = w_value;
                        if (w_empty) begin
                            n_back = w_value;
                        end
                    end
                end
                CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_tail  = ptr_next(r_tail);
                        w_we    = 1'b1;
                        w_waddr = r_tail;
                        n_count = r_count + CNT_W'(1);
                        n_back  = w_value;
                        if (w_empty) begin
                            n_front = w_value;
                        end
                    end
                end
                CMD_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = r_front;
                        n_head   = ptr_next(r_head);
                        n_count  = r_count - CNT_W'(1);
                        w_raddr  = ptr_next(r_head);
                    end
                end
                CMD_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped = r_back;
                        n_tail   = ptr_prev(r_tail);
                        n_count  = r_count - CNT_W'(1);
                        w_raddr  = ptr_prev(ptr_prev(r_tail));
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end

        // Refill the end word that the pop exposed.
        if (i_cmd.fetch) begin
            if (r_item.cmd == CMD_POP_FRONT) begin
                n_front = r_rd_data;
            end else begin
                n_back = r_rd_data;
            end
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[w_raddr];
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_front  <= n_front;
        r_back   <= n_back;
        r_item   <= n_item;
        r_status <= n_status;
        r_popped <= n_popped;
    end

    // Result beat, built from the settled state.
    always_comb begin
        o_result.popped_value = WORD_W'(r_popped);
        o_result.status       = r_status;
        o_result.entry_count  = COUNT_W'(r_count);
        o_result.is_empty     = w_empty;
        o_result.front_word   = w_empty ? '0 : WORD_W'(r_front);
        o_result.back_word    = w_empty ? '0 : WORD_W'(r_back);
    end

    // The occupancy never passes the ring size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy exceeds ring depth");

    // An empty or full ring has its pointers meeting.
    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_empty || w_full) |-> (r_head == r_tail))
        else $error("head and tail disagree with occupancy");

    // A refused push leaves the occupancy alone.
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && w_is_push && w_full) |=> (r_count == $past(r_count)))
        else $error("refused push changed occupancy");

endmodule

// ===== hdl/dq_ctrl.sv =====
`timescale 1ns / 1ps

module dq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dq_pkg::t_dp_stat i_stat,
    output dq_pkg::t_dp_cmd  o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import dq_pkg::*;

    t_state r_state, n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_stat.need_fetch ? S_FETCH : S_REPORT;
            end
            S_FETCH: begin
                n_state = S_REPORT;
            end
            S_REPORT: begin
                n_state = i_start ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output decode; a new beat may be taken while the result is shown.
    always_comb begin
        o_busy       = 1'b1;
        o_done       = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.exec   = 1'b0;
        o_cmd.fetch  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            S_REPORT: begin
                o_busy     = 1'b0;
                o_done     = 1'b1;
                o_cmd.load = i_start;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // The result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held longer than one cycle");

    // An accepted beat is executed on the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_cmd.exec)
        else $error("accepted beat not executed");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_item   i_item  = '0;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Shadow copy of the ring, kept in step with every accepted command beat.
    logic [WORD_W-1:0]  ring_words [DEPTH];
    logic [PTR_W-1:0]   front_idx = '0;
    logic [PTR_W-1:0]   tail_idx  = '0;
    logic [COUNT_W-1:0] word_total = '0;

    t_result pending_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      gap_pct = 0;

    double_ended_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    // Abort the run if the block stops answering.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Apply one command to the shadow ring and return the beat it should produce.
    function automatic t_result apply_command(t_item item);
        t_result            res;
        logic [PTR_W-1:0]   last_idx;
        res = '0;
        res.status = ST_OK;
        case (item.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (word_total == DEPTH) begin
                    res.status = ST_FULL;
                end else if (item.cmd == CMD_PUSH_FRONT) begin
                    front_idx = front_idx - 1'b1;
                    ring_words[front_idx] = item.push_value;
                    word_total = word_total + 1'b1;
                end else begin
                    ring_words[tail_idx] = item.push_value;
                    tail_idx = tail_idx + 1'b1;
                    word_total = word_total + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (word_total == 0) begin
                    res.status = ST_EMPTY;
                end else if (item.cmd == CMD_POP_FRONT) begin
                    res.popped_value = ring_words[front_idx];
                    front_idx = front_idx + 1'b1;
                    word_total = word_total - 1'b1;
                end else begin
                    tail_idx = tail_idx - 1'b1;
                    res.popped_value = ring_words[tail_idx];
                    word_total = word_total - 1'b1;
                end
            end
            default: begin
                // Query and the unused codes leave the ring alone.
            end
        endcase
        res.entry_count = word_total;
        res.is_empty = (word_total == 0);
        if (word_total != 0) begin
            last_idx = tail_idx - 1'b1;
            res.front_word = ring_words[front_idx];
            res.back_word = ring_words[last_idx];
        end
        return res;
    endfunction

    function automatic t_item make_item(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] value);
        t_item item;
        item.cmd = cmd;
        item.push_value = value;
        return item;
    endfunction

    // Drive one command beat, with random idle cycles ahead of it, and hold it
    // until the block takes it.
    task automatic send_command(t_item item);
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_item <= item;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.insert(pending_results.size(), apply_command(item));
    endtask

    // Stop sending and wait for every outstanding result beat.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic report_mismatch(string field, logic [WORD_W-1:0] want,
                                   logic [WORD_W-1:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        error_count++;
    endtask

    // Compare each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %h", $time, o_result);
                error_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_result.popped_value !== want.popped_value)
                    report_mismatch("popped_value", want.popped_value, o_result.popped_value);
                if (o_result.status !== want.status)
                    report_mismatch("status", WORD_W'(want.status),
                                    WORD_W'(o_result.status));
                if (o_result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", WORD_W'(want.entry_count),
                                    WORD_W'(o_result.entry_count));
                if (o_result.is_empty !== want.is_empty)
                    report_mismatch("is_empty", WORD_W'(want.is_empty),
                                    WORD_W'(o_result.is_empty));
                if (o_result.front_word !== want.front_word)
                    report_mismatch("front_word", want.front_word, o_result.front_word);
                if (o_result.back_word !== want.back_word)
                    report_mismatch("back_word", want.back_word, o_result.back_word);
            end
        end
    end

    // Random end for a push or a pop.
    function automatic logic [CMD_W-1:0] pick_push();
        return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    endfunction

    function automatic logic [CMD_W-1:0] pick_pop();
        return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    // Query or one of the unused codes above it.
    function automatic logic [CMD_W-1:0] pick_query();
        return CMD_QUERY + CMD_W'($urandom_range(3));
    endfunction

    // Empty-queue pops, queries, unused codes, extreme words and both ends.
    task automatic test_directed();
        gap_pct = 0;
        send_command(make_item(CMD_QUERY, 32'hFFFF_FFFF));
        send_command(make_item(CMD_QUERY + 3'd1, '0));
        send_command(make_item(CMD_QUERY + 3'd2, 32'h1234_5678));
        send_command(make_item(CMD_QUERY + 3'd3, 32'hFFFF_FFFF));
        send_command(make_item(CMD_POP_FRONT, 32'hFFFF_FFFF));
        send_command(make_item(CMD_POP_BACK, 32'hFFFF_FFFF));
        send_command(make_item(CMD_PUSH_BACK, 32'hFFFF_FFFF));
        send_command(make_item(CMD_PUSH_FRONT, '0));
        send_command(make_item(CMD_QUERY, '0));
        send_command(make_item(CMD_PUSH_BACK, 32'hA5A5_A5A5));
        send_command(make_item(CMD_PUSH_FRONT, 32'h5A5A_5A5A));
        send_command(make_item(CMD_POP_BACK, '0));
        send_command(make_item(CMD_POP_FRONT, '0));
        send_command(make_item(CMD_POP_FRONT, '0));
        send_command(make_item(CMD_POP_BACK, '0));
        send_command(make_item(CMD_POP_FRONT, '0));
        send_command(make_item(CMD_PUSH_FRONT, 32'h8000_0000));
        send_command(make_item(CMD_POP_FRONT, '0));
        send_command(make_item(CMD_PUSH_BACK, 32'h0000_0001));
        send_command(make_item(CMD_POP_BACK, '0));
        // A word pushed at one end leaves from the other.
        send_command(make_item(CMD_PUSH_FRONT, 32'h1234_5678));
        send_command(make_item(CMD_POP_BACK, '0));
        send_command(make_item(CMD_PUSH_BACK, 32'hFFFF_FFFF));
        send_command(make_item(CMD_POP_FRONT, '0));
    endtask

    // Unbiased commands keep the queue near empty and wrap both pointers.
    task automatic test_churn_near_empty();
        gap_pct = 63;
        repeat (300) send_command(make_item(CMD_W'($urandom_range(7)), $urandom()));
    endtask

    // Mostly pushes until the ring is full, then push against the full ring.
    task automatic test_fill_to_full();
        int pick;
        gap_pct = 32;
        while (word_total != DEPTH) begin
            pick = $urandom_range(99);
            if (pick < 88)
                send_command(make_item(pick_push(), $urandom()));
            else if (pick < 94)
                send_command(make_item(pick_pop(), $urandom()));
            else
                send_command(make_item(pick_query(), $urandom()));
        end
        repeat (24) begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_command(make_item(pick_push(), $urandom()));
            else if (pick < 70)
                send_command(make_item(pick_pop(), $urandom()));
            else
                send_command(make_item(pick_query(), $urandom()));
        end
    endtask

    // Pop-heavy traffic with no idle cycles, from a nearly full ring.
    task automatic test_back_to_back_drain();
        int pick;
        gap_pct = 0;
        repeat (270) begin
            pick = $urandom_range(99);
            if (pick < 60)
                send_command(make_item(pick_pop(), $urandom()));
            else if (pick < 90)
                send_command(make_item(pick_push(), $urandom()));
            else
                send_command(make_item(pick_query(), $urandom()));
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_churn_near_empty();
        drain_results();
        test_fill_to_full();
        drain_results();
        test_back_to_back_drain();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== double_ended_queue.f =====
hdl/dq_pkg.sv
hdl/dq_dp.sv
hdl/dq_ctrl.sv
hdl/double_ended_queue.sv
tb/testbench.sv
